// ===== rtl/swt_pkg.sv =====
// Shared types and codes for the lap stopwatch with tachymeter.
// Used by swt_ctrl, swt_datapath and the stopwatch_tachymeter top level.
package swt_pkg;

  // Stopwatch modes. Codes above MODE_SET0 are never entered.
  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_RUN     = 4'd1;
  localparam logic [3:0] MODE_RUNLAP  = 4'd2;
  localparam logic [3:0] MODE_STOP    = 4'd3;
  localparam logic [3:0] MODE_STOPLAP = 4'd4;
  localparam logic [3:0] MODE_SETUNIT = 4'd5;
  localparam logic [3:0] MODE_SET3    = 4'd6;
  localparam logic [3:0] MODE_SET2    = 4'd7;
  localparam logic [3:0] MODE_SET1    = 4'd8;
  localparam logic [3:0] MODE_SET0    = 4'd9;

  // Button and timer events.
  localparam logic [2:0] EV_TICK       = 3'd0;
  localparam logic [2:0] EV_ALARM_DOWN = 3'd1;
  localparam logic [2:0] EV_ALARM_UP   = 3'd2;
  localparam logic [2:0] EV_ALARM_LONG = 3'd3;
  localparam logic [2:0] EV_LIGHT_DOWN = 3'd4;
  localparam logic [2:0] EV_LIGHT_UP   = 3'd5;
  localparam logic [2:0] EV_LIGHT_LONG = 3'd6;
  localparam logic [2:0] EV_ACTIVATE   = 3'd7;

  // Distance units.
  localparam logic [2:0] UNIT_KM    = 3'd0;
  localparam logic [2:0] UNIT_M     = 3'd1;
  localparam logic [2:0] UNIT_MILES = 3'd2;
  localparam logic [2:0] UNIT_YARDS = 3'd3;
  localparam logic [2:0] UNIT_FEET  = 3'd4;

  localparam int unsigned DataW = 96;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_event;
    logic zero_speed;
    logic halve;
    logic saturate;
    logic load_div;
    logic div_step;
    logic store_speed;
    logic publish;
  } swt_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic calc;
    logic operand_zero;
    logic scale_more;
    logic elapsed_zero;
  } swt_stat_t;

  function automatic logic [3:0] bcd_inc(input logic [3:0] d);
    bcd_inc = (d == 4'd9) ? 4'd0 : d + 4'd1;
  endfunction

  function automatic logic [13:0] bcd_to_bin(input logic [3:0] d3, input logic [3:0] d2,
                                             input logic [3:0] d1, input logic [3:0] d0);
    bcd_to_bin = 14'(d3 * 14'd1000) + 14'(d2 * 14'd100) + 14'(d1 * 14'd10) + 14'(d0);
  endfunction

endpackage

// ===== rtl/swt_ctrl.sv =====
// Sequencer for the stopwatch: event acceptance, speed scaling and division steps,
// result publication. Depends on swt_pkg.
module swt_ctrl import swt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  swt_stat_t stat,
  output swt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCALE,
    ST_DIV,
    ST_STORE,
    ST_PUB
  } state_t;

  state_t     state;
  logic [4:0] div_cnt;
  logic       out_valid;

  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:  cmd.load_event = s_tvalid && s_tready;
      ST_CHECK: cmd.zero_speed = stat.calc && stat.operand_zero;
      ST_SCALE: begin
        if (stat.scale_more) begin
          cmd.halve = 1'b1;
        end else if (stat.elapsed_zero) begin
          cmd.saturate = 1'b1;
        end else begin
          cmd.load_div = 1'b1;
        end
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_STORE: cmd.store_speed = 1'b1;
      ST_PUB:   cmd.publish = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.load_event) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (stat.calc && !stat.operand_zero) begin
            state <= ST_SCALE;
          end else begin
            state <= ST_PUB;
          end
        end
        ST_SCALE: begin
          if (!stat.scale_more) begin
            div_cnt <= '0;
            state   <= stat.elapsed_zero ? ST_PUB : ST_DIV;
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            state <= ST_STORE;
          end
        end
        ST_STORE: state <= ST_PUB;
        ST_PUB:   state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/swt_datapath.sv =====
// Stopwatch state, event decoding, speed scaling and a one-bit-per-cycle divider.
// Driven by swt_ctrl through swt_cmd_t; depends on swt_pkg.
module swt_datapath import swt_pkg::*; #(
  parameter int unsigned TICK_RATE = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [2:0]       ev,
  input  logic [31:0]      now,
  input  swt_cmd_t         cmd,
  output swt_stat_t        stat,
  output logic [DataW-1:0] result
);

  localparam logic [31:0] Base   = 32'(100 * 3600 * TICK_RATE);
  localparam logic [31:0] MulM   = 32'((Base + 32'd500) / 32'd1000);
  localparam logic [31:0] MulY   = 32'((Base + 32'd880) / 32'd1760);
  localparam logic [31:0] MulF   = 32'((Base + 32'd2640) / 32'd5280);
  localparam logic [31:0] LimB   = 32'(32'hFFFF_FFFF / Base + 32'd1);
  localparam logic [31:0] LimM   = 32'(32'hFFFF_FFFF / MulM + 32'd1);
  localparam logic [31:0] LimY   = 32'(32'hFFFF_FFFF / MulY + 32'd1);
  localparam logic [31:0] LimF   = 32'(32'hFFFF_FFFF / MulF + 32'd1);

  // Stopwatch state
  logic [3:0]  mode_reg;
  logic [31:0] start_mark, lap_mark, stop_mark;
  logic [3:0]  digit [0:3];   // distance as decimal digits, digit[3] is thousands
  logic [2:0]  unit_reg;
  logic [31:0] speed_reg;
  logic        slow_reg;
  logic [31:0] now_reg;

  // Speed working registers
  logic        calc;
  logic [31:0] op_elapsed;
  logic [13:0] op_dist;
  logic [31:0] quo, rem;

  logic [3:0]  mode_next;
  logic [31:0] start_next, lap_next, stop_next, elapsed_next;
  logic [3:0]  digit_next [0:3];
  logic [2:0]  unit_next;
  logic        slow_next, calc_next;
  logic [13:0] dist_bin;
  logic        in_setting;

  logic [31:0] mul_sel, lim_sel, product;
  logic [32:0] rem_sh, diff;

  logic [31:0] shown;
  logic [5:0]  refresh;

  assign dist_bin   = bcd_to_bin(digit[3], digit[2], digit[1], digit[0]);
  assign in_setting = (mode_reg >= MODE_SETUNIT) && (mode_reg <= MODE_SET0);

  always_comb begin
    mode_next    = mode_reg;
    start_next   = start_mark;
    lap_next     = lap_mark;
    stop_next    = stop_mark;
    digit_next   = digit;
    unit_next    = unit_reg;
    slow_next    = slow_reg;
    calc_next    = 1'b0;
    elapsed_next = '0;
    if (ev == EV_ACTIVATE) begin
      if (in_setting) begin
        mode_next = MODE_IDLE;
      end
    end else begin
      case (mode_reg)
        MODE_IDLE: begin
          if (ev == EV_ALARM_DOWN) begin
            mode_next  = MODE_RUN;
            start_next = now;
          end else if (ev == EV_LIGHT_LONG) begin
            slow_next = ~slow_reg;
          end else if (ev == EV_ALARM_LONG) begin
            mode_next = MODE_SETUNIT;
          end
        end
        MODE_RUN: begin
          if (ev == EV_ALARM_DOWN) begin
            mode_next    = MODE_STOP;
            stop_next    = now;
            calc_next    = 1'b1;
            elapsed_next = now - start_mark;
          end else if (ev == EV_LIGHT_DOWN) begin
            mode_next = MODE_RUNLAP;
            lap_next  = now;
          end else if (ev == EV_ALARM_LONG) begin
            mode_next = MODE_SETUNIT;
          end
        end
        MODE_RUNLAP: begin
          if (ev == EV_ALARM_DOWN) begin
            mode_next    = MODE_STOPLAP;
            stop_next    = now;
            calc_next    = 1'b1;
            elapsed_next = now - start_mark;
          end else if (ev == EV_LIGHT_DOWN) begin
            mode_next = MODE_RUN;
            lap_next  = now;
          end else if (ev == EV_LIGHT_LONG) begin
            mode_next = MODE_RUN;
            slow_next = ~slow_reg;
          end
        end
        MODE_STOPLAP: begin
          if (ev == EV_ALARM_DOWN) begin
            mode_next  = MODE_RUNLAP;
            start_next = now - stop_mark + start_mark;
            lap_next   = now - stop_mark + lap_mark;
          end else if (ev == EV_LIGHT_DOWN) begin
            mode_next    = MODE_STOP;
            calc_next    = 1'b1;
            elapsed_next = stop_mark - start_mark;
          end
        end
        MODE_STOP: begin
          if (ev == EV_ALARM_DOWN) begin
            mode_next  = MODE_RUN;
            start_next = now - stop_mark + start_mark;
          end else if (ev == EV_LIGHT_DOWN) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_SETUNIT, MODE_SET3, MODE_SET2, MODE_SET1, MODE_SET0: begin
          if (ev == EV_ALARM_UP) begin
            case (mode_reg)
              MODE_SETUNIT: unit_next = (unit_reg >= UNIT_FEET) ? 3'(unit_reg - UNIT_FEET)
                                                                : unit_reg + 3'd1;
              MODE_SET3:    digit_next[3] = bcd_inc(digit[3]);
              MODE_SET2:    digit_next[2] = bcd_inc(digit[2]);
              MODE_SET1:    digit_next[1] = bcd_inc(digit[1]);
              MODE_SET0:    digit_next[0] = bcd_inc(digit[0]);
              default:      unit_next = unit_reg;
            endcase
          end else if (ev == EV_LIGHT_UP) begin
            mode_next = (mode_reg == MODE_SET0) ? MODE_IDLE : mode_reg + 4'd1;
          end else if (ev == EV_LIGHT_LONG) begin
            mode_next  = MODE_SETUNIT;
            digit_next = '{4'd0, 4'd0, 4'd0, 4'd0};
          end
        end
        default: mode_next = mode_reg;
      endcase
    end
  end

  // Multiplier and overflow limit for the current unit.
  always_comb begin
    case (unit_reg)
      UNIT_M:     begin mul_sel = MulM; lim_sel = LimM; end
      UNIT_YARDS: begin mul_sel = MulY; lim_sel = LimY; end
      UNIT_FEET:  begin mul_sel = MulF; lim_sel = LimF; end
      default:    begin mul_sel = Base; lim_sel = LimB; end
    endcase
  end

  assign product = {18'd0, op_dist} * mul_sel;
  assign rem_sh  = {rem, quo[31]};
  assign diff    = rem_sh - {1'b0, op_elapsed};

  assign stat.calc         = calc;
  assign stat.operand_zero = (op_elapsed == '0) || (op_dist == '0);
  assign stat.scale_more   = {18'd0, op_dist} > lim_sel;
  assign stat.elapsed_zero = (op_elapsed == '0);

  always_comb begin
    case (mode_reg)
      MODE_RUN:                  shown = now_reg - start_mark;
      MODE_RUNLAP, MODE_STOPLAP: shown = lap_mark - start_mark;
      MODE_STOP:                 shown = stop_mark - start_mark;
      default:                   shown = '0;
    endcase
    case (mode_reg)
      MODE_RUN:    refresh = slow_reg ? 6'd2 : 6'd32;
      MODE_RUNLAP: refresh = 6'd2;
      MODE_SETUNIT, MODE_SET3, MODE_SET2, MODE_SET1, MODE_SET0: refresh = 6'd4;
      default:     refresh = 6'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= MODE_IDLE;
      start_mark <= '0;
      lap_mark   <= '0;
      stop_mark  <= '0;
      digit      <= '{4'd0, 4'd0, 4'd0, 4'd0};
      unit_reg   <= UNIT_KM;
      speed_reg  <= '0;
      slow_reg   <= 1'b0;
      calc       <= 1'b0;
    end else begin
      if (cmd.load_event) begin
        mode_reg   <= mode_next;
        start_mark <= start_next;
        lap_mark   <= lap_next;
        stop_mark  <= stop_next;
        digit      <= digit_next;
        unit_reg   <= unit_next;
        slow_reg   <= slow_next;
        calc       <= calc_next;
      end
      if (cmd.zero_speed) begin
        speed_reg <= '0;
      end else if (cmd.saturate) begin
        speed_reg <= '1;
      end else if (cmd.store_speed) begin
        speed_reg <= quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_event) begin
      now_reg    <= now;
      op_elapsed <= elapsed_next;
      op_dist    <= dist_bin;
    end else if (cmd.halve) begin
      op_elapsed <= op_elapsed >> 1;
      op_dist    <= op_dist >> 1;
    end
    // The dividend is the rounded product; one quotient bit is resolved per step.
    if (cmd.load_div) begin
      quo <= product + (op_elapsed >> 1);
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (cmd.publish) begin
      result <= {4'd0, refresh, slow_reg, unit_reg, dist_bin, speed_reg, shown, mode_reg};
    end
  end

endmodule

// ===== rtl/stopwatch_tachymeter.sv =====
// Lap stopwatch with tachymeter: one result item per event item.
// With no speed to compute, an item passes through the check and publish states only. A stop with
// non-zero operands first halves time and distance (seven halving steps at most at the default
// tick rate), then saturates the speed when the time halves to nothing and else runs the
// 32-step restoring divider. No new item is taken before the last one is through and its result is taken.
// Reset (rst, synchronous, active high) returns to idle with all marks, distance,
// unit, speed and slow flag cleared; no result is pending afterwards.
module stopwatch_tachymeter import swt_pkg::*; #(
  parameter int unsigned TICK_RATE = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // now_ticks[31:0]
  input  logic [2:0]       s_tuser,   // opcode[2:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [DataW-1:0] m_tdata    // mode[3:0], elapsed_ticks[35:4],
                                      // speed_hundredths[67:36], distance_value[81:68],
                                      // unit_code[84:82], slow_flag[85],
                                      // refresh_rate[91:86], zero[95:92]
);

  swt_cmd_t  cmd;
  swt_stat_t stat;

  swt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swt_datapath #(
    .TICK_RATE (TICK_RATE)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ev     (s_tuser),
    .now    (s_tdata),
    .cmd    (cmd),
    .stat   (stat),
    .result (m_tdata)
  );

endmodule
